// ===== sv/igs_pkg.sv =====
`default_nettype none
package igs_pkg;
  // Root of a 128-bit radicand (64 result bits), one bit per stage.
  localparam int unsigned SqrtBits = 64;
  // Root division: quotient bits that can be nonzero. X never exceeds mean < 2^32,
  // but the quotient is clamped, so 33 bits cover the saturation test.
  localparam int unsigned XqBits = 33;
  // Reciprocal quotient: mean^2 / Xr, 64-bit dividend, 33 bits kept for saturation.
  localparam int unsigned RqBits = 33;

  // Data that rides beside the arithmetic through the whole pipeline.
  typedef struct packed {
    logic        valid;
    logic [31:0] mean;
    logic [15:0] u;
    logic        last;
    logic        bad;
  } igs_side_t;
endpackage
`default_nettype wire

// ===== sv/inverse_gaussian_sampler.sv =====
`default_nettype none
// Inverse Gaussian sampler (Michael-Schucany-Haas). Each request carries a Q16.16 mean,
// a Q4.12 normal draw and a Q0.16 uniform draw; the result is a Q16.16 sample using
// the configured Q16.16 shape. The pipeline takes one request per cycle unless stalled
// and returns one result per request in order, through the 64 stages of the bit-serial
// square root, the two 33-stage dividers and 11 further registers.
// Stall on the output freezes the whole pipeline. A zero mean or shape gives sample 0
// with invalid set; a reciprocal above range saturates to all ones with invalid set.
// Write shape only while no requests are in flight.
module inverse_gaussian_sampler (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] mean,
  input  wire logic [15:0] normal_draw,
  input  wire logic [15:0] uniform_draw,
  input  wire logic        last_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      sample,
  output logic             took_reciprocal,
  output logic             invalid,
  output logic             last_out
);
  logic [31:0] shape;
  logic        en;

  // Whole pipeline advances unless a finished result is held.
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      shape <= 32'h0001_0000;
    end else if (cfg_valid) begin
      shape <= cfg_data;
    end
  end

  // Stage 1: |z|^2; W = mean * z^2 is formed in the next stage.
  igs_pkg::igs_side_t s1;
  logic [31:0] z2;
  logic [15:0] za;
  always_comb begin
    za = normal_draw[15] ? (16'd0 - normal_draw) : normal_draw;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (en) begin
      s1.valid <= in_valid;
    end
    if (en) begin
      s1.mean <= mean;
      s1.u    <= uniform_draw;
      s1.last <= last_in;
      s1.bad  <= (mean == 32'd0) || (shape == 32'd0);
      z2      <= za * za;
    end
  end

  igs_pkg::igs_side_t s2;
  logic [63:0] wr2;
  logic [31:0] shape2;
  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else if (en) begin
      s2.valid <= s1.valid;
    end
    if (en) begin
      s2.mean <= s1.mean;
      s2.u    <= s1.u;
      s2.last <= s1.last;
      s2.bad  <= s1.bad;
      wr2     <= s1.mean * z2;
      shape2  <= shape;
    end
  end

  // Stage 3: W + 4*shape. W stays below 2^62 and 4*shape below 2^58, so 64 bits hold it.
  igs_pkg::igs_side_t s3;
  logic [63:0] sum3;
  logic [63:0] wr3;
  logic [31:0] shape3;
  always_ff @(posedge clk) begin
    if (rst) begin
      s3.valid <= 1'b0;
    end else if (en) begin
      s3.valid <= s2.valid;
    end
    if (en) begin
      s3.mean <= s2.mean;
      s3.u    <= s2.u;
      s3.last <= s2.last;
      s3.bad  <= s2.bad;
      sum3    <= wr2 + {6'd0, shape2, 26'd0};
      wr3     <= wr2;
      shape3  <= shape2;
    end
  end

  // Stage 4: radicand W * (W + 4*shape), product cut into four 32x32 partials.
  igs_pkg::igs_side_t s4;
  logic [63:0] pll, plh, phl, phh;
  logic [63:0] wr4;
  logic [31:0] shape4;
  always_ff @(posedge clk) begin
    if (rst) begin
      s4.valid <= 1'b0;
    end else if (en) begin
      s4.valid <= s3.valid;
    end
    if (en) begin
      s4.mean <= s3.mean;
      s4.u    <= s3.u;
      s4.last <= s3.last;
      s4.bad  <= s3.bad;
      pll     <= wr3[31:0] * sum3[31:0];
      plh     <= wr3[31:0] * sum3[63:32];
      phl     <= wr3[63:32] * sum3[31:0];
      phh     <= wr3[63:32] * sum3[63:32];
      wr4     <= wr3;
      shape4  <= shape3;
    end
  end

  // Stage 5: sum of the partials; the radicand stays below 2^125.
  igs_pkg::igs_side_t s5;
  logic [127:0] rad5;
  logic [63:0]  wr5;
  logic [31:0]  shape5;
  always_ff @(posedge clk) begin
    if (rst) begin
      s5.valid <= 1'b0;
    end else if (en) begin
      s5.valid <= s4.valid;
    end
    if (en) begin
      s5.mean <= s4.mean;
      s5.u    <= s4.u;
      s5.last <= s4.last;
      s5.bad  <= s4.bad;
      rad5    <= {64'd0, pll} + {32'd0, plh, 32'd0} + {32'd0, phl, 32'd0}
                 + {phh, 64'd0};
      wr5     <= wr4;
      shape5  <= shape4;
    end
  end

  // Stage 6: register in front of the square root.
  igs_pkg::igs_side_t s6;
  logic [127:0] rad6;
  logic [63:0]  wr6;
  logic [31:0]  shape6;
  always_ff @(posedge clk) begin
    if (rst) begin
      s6.valid <= 1'b0;
    end else if (en) begin
      s6.valid <= s5.valid;
    end
    if (en) begin
      s6.mean <= s5.mean;
      s6.u    <= s5.u;
      s6.last <= s5.last;
      s6.bad  <= s5.bad;
      rad6    <= rad5;
      wr6     <= wr5;
      shape6  <= shape5;
    end
  end

  igs_pkg::igs_side_t sq_side;
  logic [63:0] sq_root, sq_wr;
  logic [31:0] sq_shape;
  igs_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .side_in(s6), .rad_in(rad6), .wr_in(wr6), .shape_in(shape6),
    .side_out(sq_side), .root_out(sq_root), .wr_out(sq_wr), .shape_out(sq_shape)
  );

  // Denominator D and numerator mean*shape*2^25.
  igs_pkg::igs_side_t s7;
  logic [65:0] den7;
  logic [63:0] ml7;
  always_ff @(posedge clk) begin
    if (rst) begin
      s7.valid <= 1'b0;
    end else if (en) begin
      s7.valid <= sq_side.valid;
    end
    if (en) begin
      s7.mean <= sq_side.mean;
      s7.u    <= sq_side.u;
      s7.last <= sq_side.last;
      s7.bad  <= sq_side.bad;
      den7    <= {9'd0, sq_shape, 25'd0} + {2'd0, sq_wr} + {2'd0, sq_root};
      ml7     <= sq_side.mean * sq_shape;
    end
  end

  igs_pkg::igs_side_t xd_side;
  logic [32:0] xq;
  logic        xovf;
  logic [31:0] xd_aux;
  igs_div u_xdiv (
    .clk(clk), .rst(rst), .en(en),
    .side_in(s7), .num_in({39'd0, ml7, 25'd0}), .den_in({30'd0, den7}), .aux_in(32'd0),
    .side_out(xd_side), .quo_out(xq), .ovf_out(xovf), .aux_out(xd_aux)
  );

  // Clamp X, then the branch test.
  igs_pkg::igs_side_t s8;
  logic [31:0] xr8;
  logic [32:0] xc;
  always_comb begin
    xc = (xovf || xq[32]) ? 33'h0_FFFF_FFFF : xq;
    if (xc > {1'b0, xd_side.mean}) xc = {1'b0, xd_side.mean};
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      s8.valid <= 1'b0;
    end else if (en) begin
      s8.valid <= xd_side.valid;
    end
    if (en) begin
      s8.mean <= xd_side.mean;
      s8.u    <= xd_side.u;
      s8.last <= xd_side.last;
      s8.bad  <= xd_side.bad;
      xr8     <= xc[31:0] | (xd_aux & 32'd0);
    end
  end

  igs_pkg::igs_side_t s9;
  logic [31:0] xr9;
  logic [48:0] lhs9;
  logic [63:0] msq9;
  always_ff @(posedge clk) begin
    if (rst) begin
      s9.valid <= 1'b0;
    end else if (en) begin
      s9.valid <= s8.valid;
    end
    if (en) begin
      s9.mean <= s8.mean;
      s9.u    <= s8.u;
      s9.last <= s8.last;
      s9.bad  <= s8.bad;
      xr9     <= xr8;
      lhs9    <= s8.u * ({1'b0, s8.mean} + {1'b0, xr8});
      msq9    <= s8.mean * s8.mean;
    end
  end

  igs_pkg::igs_side_t s10;
  logic [31:0] xr10;
  logic        rec10;
  logic [63:0] msq10;
  always_ff @(posedge clk) begin
    if (rst) begin
      s10.valid <= 1'b0;
    end else if (en) begin
      s10.valid <= s9.valid;
    end
    if (en) begin
      s10.mean <= s9.mean;
      s10.u    <= s9.u;
      s10.last <= s9.last;
      s10.bad  <= s9.bad;
      xr10     <= xr9;
      msq10    <= msq9;
      rec10    <= (xr9 != 32'd0) && (lhs9 > {1'b0, s9.mean, 16'd0});
    end
  end

  // Reciprocal mean^2 / X; divisor forced to 1 when unused to avoid a zero divide.
  igs_pkg::igs_side_t rd_side;
  logic [32:0] rq;
  logic        rovf;
  logic [31:0] rd_aux;
  igs_div u_rdiv (
    .clk(clk), .rst(rst), .en(en),
    .side_in(s10), .num_in({64'd0, msq10}),
    .den_in({64'd0, (xr10 == 32'd0) ? 32'd1 : xr10}),
    .aux_in({xr10[31:1], 1'b0}),
    .side_out(rd_side), .quo_out(rq), .ovf_out(rovf), .aux_out(rd_aux)
  );

  // X's low bit and the chosen branch ride in delay lines beside the divider; aux carries X with bit 0 cleared.
  logic rec_d [igs_pkg::RqBits+1];
  logic [0:0] xlow [igs_pkg::RqBits+1];
  assign rec_d[0] = rec10;
  assign xlow[0]  = xr10[0];
  for (genvar k = 0; k < igs_pkg::RqBits; k++) begin : g_rec
    always_ff @(posedge clk) begin
      if (en) begin
        rec_d[k+1] <= rec_d[k];
        xlow[k+1]  <= xlow[k];
      end
    end
  end

  // Output register.
  logic        sat;
  logic        rec_f;
  assign rec_f = rec_d[igs_pkg::RqBits];
  assign sat   = rovf || rq[32];
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= rd_side.valid;
    end
    if (en) begin
      last_out <= rd_side.last;
      if (rd_side.bad) begin
        sample          <= 32'd0;
        took_reciprocal <= 1'b0;
        invalid         <= 1'b1;
      end else if (rec_f) begin
        sample          <= sat ? 32'hFFFF_FFFF : rq[31:0];
        took_reciprocal <= 1'b1;
        invalid         <= sat;
      end else begin
        sample          <= {rd_aux[31:1], xlow[igs_pkg::RqBits]};
        took_reciprocal <= 1'b0;
        invalid         <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/igs_sqrt.sv =====
`default_nettype none
// Pipelined restoring square root of a 128-bit value, one result bit per stage.
// Carries the sideband and two extra payload words alongside. Stall freezes all stages.
module igs_sqrt (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire igs_pkg::igs_side_t side_in,
  input  wire logic [127:0]      rad_in,
  input  wire logic [63:0]       wr_in,
  input  wire logic [31:0]       shape_in,
  output igs_pkg::igs_side_t     side_out,
  output logic [63:0]            root_out,
  output logic [63:0]            wr_out,
  output logic [31:0]            shape_out
);
  localparam int unsigned N = igs_pkg::SqrtBits;

  igs_pkg::igs_side_t side [N+1];
  logic [127:0] rem  [N+1];
  logic [63:0]  root [N+1];
  logic [63:0]  wr   [N+1];
  logic [31:0]  shp  [N+1];

  assign side[0] = side_in;
  assign rem[0]  = rad_in;
  assign root[0] = '0;
  assign wr[0]   = wr_in;
  assign shp[0]  = shape_in;

  // Each stage trial-subtracts (2*root + 1) << bit from the remainder.
  for (genvar s = 0; s < N; s++) begin : g_stage
    localparam int unsigned B = N - 1 - s;
    logic [129:0] trial;
    logic         fits;
    always_comb begin
      trial = ({66'd0, root[s]} << (B + 1)) + (130'd1 << (2 * B));
      fits  = {2'b00, rem[s]} >= trial;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        side[s+1].valid <= 1'b0;
      end else if (en) begin
        side[s+1].valid <= side[s].valid;
      end
      if (en) begin
        side[s+1].mean <= side[s].mean;
        side[s+1].u    <= side[s].u;
        side[s+1].last <= side[s].last;
        side[s+1].bad  <= side[s].bad;
        rem[s+1]  <= fits ? (rem[s] - trial[127:0]) : rem[s];
        root[s+1] <= fits ? (root[s] | (64'd1 << B)) : root[s];
        wr[s+1]   <= wr[s];
        shp[s+1]  <= shp[s];
      end
    end
  end

  assign side_out  = side[N];
  assign root_out  = root[N];
  assign wr_out    = wr[N];
  assign shape_out = shp[N];
endmodule
`default_nettype wire

// ===== sv/igs_div.sv =====
`default_nettype none
// Pipelined restoring divider: 128-bit dividend whose quotient fits in XqBits bits
// (the caller guarantees or clamps). One quotient bit per stage. Carries the sideband
// and one payload word. Quotient bits above XqBits are reported through ovf.
module igs_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire igs_pkg::igs_side_t side_in,
  input  wire logic [127:0]      num_in,
  input  wire logic [95:0]       den_in,
  input  wire logic [31:0]       aux_in,
  output igs_pkg::igs_side_t     side_out,
  output logic [32:0]            quo_out,
  output logic                   ovf_out,
  output logic [31:0]            aux_out
);
  localparam int unsigned N = igs_pkg::XqBits;

  igs_pkg::igs_side_t side [N+1];
  logic [128:0] rem [N+1];
  logic [127:0] num [N+1];
  logic [95:0]  den [N+1];
  logic [32:0]  quo [N+1];
  logic         ovf [N+1];
  logic [31:0]  aux [N+1];

  logic [128:0] hi_part;
  always_comb begin
    // Quotient overflows XqBits exactly when num >> XqBits >= den.
    hi_part = {{N{1'b0}}, 1'b0, num_in[127:N]};
  end

  assign side[0] = side_in;
  assign rem[0]  = hi_part;
  assign num[0]  = num_in;
  assign den[0]  = den_in;
  assign quo[0]  = '0;
  assign ovf[0]  = hi_part >= {33'd0, den_in};
  assign aux[0]  = aux_in;

  for (genvar s = 0; s < N; s++) begin : g_stage
    localparam int unsigned B = N - 1 - s;
    logic [128:0] sh;
    logic         fits;
    always_comb begin
      sh   = {rem[s][127:0], num[s][B]};
      fits = sh >= {33'd0, den[s]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        side[s+1].valid <= 1'b0;
      end else if (en) begin
        side[s+1].valid <= side[s].valid;
      end
      if (en) begin
        side[s+1].mean <= side[s].mean;
        side[s+1].u    <= side[s].u;
        side[s+1].last <= side[s].last;
        side[s+1].bad  <= side[s].bad;
        rem[s+1] <= fits ? (sh - {33'd0, den[s]}) : sh;
        num[s+1] <= num[s];
        den[s+1] <= den[s];
        quo[s+1] <= {quo[s][31:0], fits};
        ovf[s+1] <= ovf[s];
        aux[s+1] <= aux[s];
      end
    end
  end

  assign side_out = side[N];
  assign quo_out  = quo[N];
  assign ovf_out  = ovf[N];
  assign aux_out  = aux[N];
endmodule
`default_nettype wire

// ===== tb/sv/inverse_gaussian_sampler_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module inverse_gaussian_sampler_tb;

  typedef struct packed {
    logic [31:0] mean;
    logic [15:0] z;
    logic [15:0] u;
    logic        last;
  } draw_t;

  typedef struct packed {
    logic [31:0] sample;
    logic        recip;
    logic        invalid;
    logic        last;
  } ig_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] mean = '0;
  logic [15:0] normal_draw = '0;
  logic [15:0] uniform_draw = '0;
  logic        last_in = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] sample;
  logic        took_reciprocal;
  logic        invalid;
  logic        last_out;

  inverse_gaussian_sampler u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .mean(mean),
    .normal_draw(normal_draw), .uniform_draw(uniform_draw), .last_in(last_in),
    .out_valid(out_valid), .out_stall(out_stall), .sample(sample),
    .took_reciprocal(took_reciprocal), .invalid(invalid), .last_out(last_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  draw_t pending_draws[$];
  ig_t   expected_samples[$];
  logic [31:0] shape_q = 32'd65536;
  int    mismatches = 0;
  int    send_gap = 0;
  int    recv_gap = 0;
  bit    quiet = 1'b0;

  // Integer square root of a 128-bit value, one bit at a time from the top.
  function automatic logic [63:0] isqrt128(logic [127:0] v);
    logic [63:0]  r;
    logic [63:0]  c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= v) r = c;
    end
    return r;
  endfunction

  // Expected sample for one request under the current shape.
  function automatic ig_t ig_predict(draw_t d, logic [31:0] lam);
    ig_t          o;
    logic [15:0]  za;
    logic [63:0]  wr;
    logic [127:0] sr;
    logic [127:0] dr;
    logic [127:0] num;
    logic [127:0] xq;
    logic [63:0]  xr;
    logic [63:0]  q;
    o = '0;
    o.last = d.last;
    if (d.mean == 0 || lam == 0) begin
      o.invalid = 1'b1;
      return o;
    end
    za = d.z[15] ? 16'(17'h10000 - {1'b0, d.z}) : d.z;
    if (d.z == 16'h8000) za = 16'h8000;
    wr = 64'(d.mean) * (64'(za) * 64'(za));
    sr = 128'(isqrt128(128'(wr) * (128'(wr) + (128'(lam) << 26))));
    dr = (128'(lam) << 25) + 128'(wr) + sr;
    num = (128'(d.mean) * 128'(lam)) << 25;
    xq = num / dr;
    xr = (xq > 128'hFFFFFFFF) ? 64'hFFFFFFFF : xq[63:0];
    if (xr > 64'(d.mean)) xr = 64'(d.mean);
    if (xr != 0 && 64'(d.u) * (64'(d.mean) + xr) > (64'(d.mean) << 16)) begin
      q = (64'(d.mean) * 64'(d.mean)) / xr;
      o.recip = 1'b1;
      if (q > 64'hFFFFFFFF) begin
        o.sample = 32'hFFFFFFFF;
        o.invalid = 1'b1;
      end else begin
        o.sample = q[31:0];
      end
    end else begin
      o.sample = xr[31:0];
    end
    return o;
  endfunction

  // Request driver: random bursts of idle cycles unless in the quiet tail.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_samples.push_back(ig_predict({mean, normal_draw, uniform_draw, last_in},
                                              shape_q));
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
          send_gap <= $urandom_range(0, 9);
          in_valid <= 1'b0;
        end else if (pending_draws.size() > 0) begin
          draw_t d;
          d = pending_draws.pop_front();
          in_valid <= 1'b1;
          mean <= d.mean;
          normal_draw <= d.z;
          uniform_draw <= d.u;
          last_in <= d.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random receive stalls.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        ig_t e;
        if (expected_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected sample %h", sample);
        end else begin
          e = expected_samples.pop_front();
          if (e.sample !== sample || e.recip !== took_reciprocal ||
              e.invalid !== invalid || e.last !== last_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %h/%b/%b/%b got %h/%b/%b/%b", e.sample, e.recip,
                       e.invalid, e.last, sample, took_reciprocal, invalid, last_out);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        recv_gap <= $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic draw_t rand_draw();
    draw_t d;
    case ($urandom_range(0, 5))
      0: d.mean = $urandom;
      1: d.mean = $urandom_range(0, 255);
      2: d.mean = 32'(1) << $urandom_range(0, 31);
      default: d.mean = $urandom_range(32'h100, 32'h80000);
    endcase
    d.z = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($signed(12'($urandom)));
    d.u = $urandom;
    d.last = $urandom_range(0, 7) == 0;
    return d;
  endfunction

  task automatic wait_drained();
    while (pending_draws.size() > 0 || in_valid || expected_samples.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_shape(logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shape_q = v;
  endtask

  // Stimulus: directed corners, then random phases across several shapes.
  initial begin
    logic [31:0] shapes[6];
    shapes = '{32'd65536, 32'd1, 32'hFFFFFFFF, 32'h00008000, 32'h00300000, 32'd0};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    pending_draws.push_back({32'd0, 16'h1000, 16'h8000, 1'b0});
    pending_draws.push_back({32'hFFFFFFFF, 16'h7FFF, 16'hFFFF, 1'b1});
    pending_draws.push_back({32'hFFFFFFFF, 16'h8000, 16'hFFFF, 1'b0});
    pending_draws.push_back({32'd1, 16'h0000, 16'h0000, 1'b0});
    pending_draws.push_back({32'd1, 16'h7FFF, 16'hFFFF, 1'b1});
    pending_draws.push_back({32'h00010000, 16'h1000, 16'h0000, 1'b0});
    pending_draws.push_back({32'h00010000, 16'hF000, 16'hFFFF, 1'b0});
    pending_draws.push_back({32'h00010000, 16'h0000, 16'hFFFF, 1'b0});
    pending_draws.push_back({32'h80000000, 16'h0001, 16'hFFFF, 1'b1});
    pending_draws.push_back({32'h00000100, 16'hFFFF, 16'h0001, 1'b0});
    // Stimulus waits until every pending sample has come back.
    wait_drained();
    for (int p = 0; p < 6; p++) begin
      write_shape(shapes[p]);
      if (p == 0) pending_draws.push_back({32'hFFFFFFFF, 16'h7FFF, 16'hFFFF, 1'b0});
      for (int i = 0; i < 220; i++) pending_draws.push_back(rand_draw());
      if (p == 5) begin
        while (pending_draws.size() >= 60) @(posedge clk);
        quiet = 1'b1;
      end
      wait_drained();
    end
    write_shape(32'd65536);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
